// File: src/bc13_pkg.sv
// ----------------------------------------------------------------------------
// bc13_pkg: shared types, constants and arithmetic helpers
// Palette types, register index codes and constant-divide helpers used by
// the BC1/BC3 block decoder lanes and merge stage.
// ----------------------------------------------------------------------------
package bc13_pkg;

  localparam int MAX_IMAGE_WIDTH = 4096;
  localparam int COL_W           = 10;
  localparam int ROW_W           = 10;
  localparam int BPR_W           = 11;
  localparam int CFG_DATA_W      = 11;
  localparam int PIX_PER_BLK     = 16;
  localparam int CNT_W           = $clog2(PIX_PER_BLK);

  // Largest usable blocks per row: min(MAX_IMAGE_WIDTH/4, 1024), at least 1
  localparam int ROW_LIMIT_RAW = (MAX_IMAGE_WIDTH / 4 > 1024) ? 1024 : MAX_IMAGE_WIDTH / 4;
  localparam int ROW_LIMIT     = (ROW_LIMIT_RAW < 1) ? 1 : ROW_LIMIT_RAW;

  typedef enum logic [0:0] {
    REG_FORMAT_MODE    = 1'b0,
    REG_BLOCKS_PER_ROW = 1'b1
  } bc13_reg_t;

  typedef logic [3:0][7:0] bc13_chan_pal_t;
  typedef logic [7:0][7:0] bc13_alpha_pal_t;

  typedef struct packed {
    bc13_chan_pal_t  pal_r;
    bc13_chan_pal_t  pal_g;
    bc13_chan_pal_t  pal_b;
    bc13_alpha_pal_t apal;
    logic [31:0]     codes;
    logic [47:0]     acodes;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } bc13_blk_t;

  // floor(c*255/31) = 8c + floor(7c/31), the latter by reciprocal 265/2^13
  function automatic logic [7:0] exp5(input logic [4:0] c);
    logic [15:0] p;
    p = {11'd0, c} * 16'd1855;
    return {c, 3'b000} + {5'd0, p[15:13]};
  endfunction

  // floor(c*255/63) = 4c + floor(c/21), the latter by reciprocal 49/2^10
  function automatic logic [7:0] exp6(input logic [5:0] c);
    logic [11:0] p;
    p = {6'd0, c} * 12'd49;
    return {c, 2'b00} + {6'd0, p[11:10]};
  endfunction

  // floor(x/3) for x <= 767: x*2731 >> 13
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [22:0] p;
    p = {13'd0, x} * 23'd2731;
    return p[20:13];
  endfunction

  // floor(x/7) for x <= 1785: x*2341 >> 14
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

  // floor(x/5) for x <= 1275: x*1639 >> 13
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd1639;
    return p[20:13];
  endfunction

endpackage

// File: src/bc13_if.sv
// ----------------------------------------------------------------------------
// bc13 channel interfaces
// Valid/ready channels for compressed blocks and decoded pixels.
// ----------------------------------------------------------------------------
interface bc13_blk_if;
  logic        valid;
  logic        ready;
  logic [15:0] color_end0;
  logic [15:0] color_end1;
  logic [31:0] color_codes;
  logic [7:0]  alpha_end0;
  logic [7:0]  alpha_end1;
  logic [47:0] alpha_codes;

  modport source (
    output valid, color_end0, color_end1, color_codes, alpha_end0, alpha_end1,
           alpha_codes,
    input  ready
  );
  modport sink (
    input  valid, color_end0, color_end1, color_codes, alpha_end0, alpha_end1,
           alpha_codes,
    output ready
  );
endinterface

interface bc13_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic        last_pixel;

  modport source (
    output valid, red, green, blue, alpha, pixel_x, pixel_y, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, alpha, pixel_x, pixel_y, last_pixel,
    output ready
  );
endinterface

// File: src/bc13_color_lane.sv
// ----------------------------------------------------------------------------
// bc13_color_lane: one color channel palette lane
// Registers the two expanded endpoints, then builds the four-entry palette.
// ----------------------------------------------------------------------------
module bc13_color_lane
  import bc13_pkg::*;
(
  input  logic           clk,
  input  logic           en1,
  input  logic           en2,
  input  logic [7:0]     end0,
  input  logic [7:0]     end1,
  output bc13_chan_pal_t pal
);

  logic [7:0] e0;
  logic [7:0] e1;
  logic [9:0] sum_a;
  logic [9:0] sum_b;

  always_ff @(posedge clk) begin
    if (en1) begin
      e0 <= end0;
      e1 <= end1;
    end
  end

  assign sum_a = {1'b0, e0, 1'b0} + {2'b00, e1};
  assign sum_b = {2'b00, e0} + {1'b0, e1, 1'b0};

  always_ff @(posedge clk) begin
    if (en2) begin
      pal[0] <= e0;
      pal[1] <= e1;
      pal[2] <= div3(sum_a);
      pal[3] <= div3(sum_b);
    end
  end

endmodule

// File: src/bc13_alpha_lane.sv
// ----------------------------------------------------------------------------
// bc13_alpha_lane: one interpolated alpha palette entry
// Forms the weighted endpoint sum, then divides by 7 or 5 per palette kind.
// ----------------------------------------------------------------------------
module bc13_alpha_lane
  import bc13_pkg::*;
(
  input  logic       clk,
  input  logic       en1,
  input  logic       en2,
  input  logic [2:0] idx,
  input  logic [7:0] a0,
  input  logic [7:0] a1,
  output logic [7:0] entry
);

  logic        gt;
  logic [2:0]  w0;
  logic [2:0]  w1;
  logic [10:0] prod0;
  logic [10:0] prod1;
  logic        gt_r;
  logic [10:0] sum_r;

  assign gt = (a0 > a1);

  // Eight-entry palette weights (8-i, i-1), six-entry ones (6-i, i-1)
  always_comb begin
    w1 = idx - 3'd1;
    if (gt) begin
      w0 = 3'd0 - idx;
    end else begin
      w0 = 3'd6 - idx;
    end
  end

  assign prod0 = {3'd0, a0} * {8'd0, w0};
  assign prod1 = {3'd0, a1} * {8'd0, w1};

  always_ff @(posedge clk) begin
    if (en1) begin
      gt_r  <= gt;
      sum_r <= prod0 + prod1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      if (gt_r) begin
        entry <= div7(sum_r);
      end else if (idx == 3'd6) begin
        entry <= 8'd0;
      end else if (idx == 3'd7) begin
        entry <= 8'd255;
      end else begin
        entry <= div5(sum_r);
      end
    end
  end

endmodule

// File: src/bc13_merge.sv
// ----------------------------------------------------------------------------
// bc13_merge: pixel merge and output stage
// Holds one decoded block and walks its sixteen pixels into the output
// register, selecting color and alpha palette entries per pixel.
// ----------------------------------------------------------------------------
module bc13_merge
  import bc13_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             format_mode,
  input  logic             load_valid,
  output logic             load_ready,
  input  bc13_blk_t        load_blk,
  bc13_pix_if.source       pixels
);

  bc13_blk_t        blk;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             fire;
  logic             last;
  logic [1:0]       ci;
  logic [2:0]       ai;
  logic [5:0]       abit;

  assign fire       = busy && (!pixels.valid || pixels.ready);
  assign last       = (cnt == CNT_W'(PIX_PER_BLK - 1));
  assign load_ready = !busy || (fire && last);

  assign abit = 6'({cnt, 1'b0}) + 6'(cnt);
  assign ci   = blk.codes[{cnt, 1'b0} +: 2];
  assign ai   = blk.acodes[abit +: 3];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      blk <= load_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (fire) begin
      pixels.valid <= 1'b1;
    end else if (pixels.ready) begin
      pixels.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pixels.red        <= blk.pal_r[ci];
      pixels.green      <= blk.pal_g[ci];
      pixels.blue       <= blk.pal_b[ci];
      pixels.alpha      <= format_mode ? blk.apal[ai] : 8'hFF;
      pixels.pixel_x    <= {blk.col, cnt[1:0]};
      pixels.pixel_y    <= {blk.row, cnt[3:2]};
      pixels.last_pixel <= last;
    end
  end

endmodule

// File: src/bc1_bc3_block_decoder.sv
// ----------------------------------------------------------------------------
// bc1_bc3_block_decoder: BC1/BC3 texture block decoder
// Decodes one compressed 4x4 block per beat into sixteen RGBA8 pixel beats.
// ----------------------------------------------------------------------------
// Each accepted block beat yields sixteen pixel beats in raster order, one per
// cycle while the pixel channel is ready; the single pixel output register
// sets that rate. A block passes an endpoint stage and a palette stage (three
// color lanes and six alpha lanes side by side) before the merge stage loads
// it into its block register and emits its pixels via the output register,
// and up to two further blocks queue in those stages while the merge emits.
// Pixel coordinates come from a block column and row counter that advances on
// every accepted block and wraps at blocks_per_row (0 acts as 1, large values
// clamp to the image width limit).
// Write format_mode and blocks_per_row only while the decoder is idle.
// ----------------------------------------------------------------------------
module bc1_bc3_block_decoder
  import bc13_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  bc13_reg_t             cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bc13_blk_if.sink              blocks,
  bc13_pix_if.source            pixels
);

  // Configuration registers
  logic             format_mode;
  logic [BPR_W-1:0] blocks_per_row;

  // Block position counter
  logic [COL_W-1:0] block_column;
  logic [ROW_W-1:0] block_row;
  logic [COL_W-1:0] block_column_next;
  logic [ROW_W-1:0] block_row_next;
  logic [BPR_W-1:0] row_limit;

  // Stage control
  logic accept;
  logic s1_valid;
  logic s2_valid;
  logic s1_adv;
  logic s2_adv;
  logic load_ready;

  // Side data carried alongside the lanes
  logic [31:0]      s1_codes;
  logic [47:0]      s1_acodes;
  logic [7:0]       s1_a0;
  logic [7:0]       s1_a1;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [31:0]      s2_codes;
  logic [47:0]      s2_acodes;
  logic [7:0]       s2_a0;
  logic [7:0]       s2_a1;
  logic [COL_W-1:0] s2_col;
  logic [ROW_W-1:0] s2_row;

  bc13_chan_pal_t  pal_r;
  bc13_chan_pal_t  pal_g;
  bc13_chan_pal_t  pal_b;
  bc13_alpha_pal_t apal;
  bc13_blk_t       s2_blk;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode    <= 1'b0;
      blocks_per_row <= BPR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT_MODE:    format_mode    <= cfg_data[0];
        REG_BLOCKS_PER_ROW: blocks_per_row <= cfg_data[BPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row length: zero acts as one, clamp to the width limit
  always_comb begin
    if (blocks_per_row == '0) begin
      row_limit = BPR_W'(1);
    end else if (blocks_per_row > BPR_W'(ROW_LIMIT)) begin
      row_limit = BPR_W'(ROW_LIMIT);
    end else begin
      row_limit = blocks_per_row;
    end
  end

  // Handshake: advance each stage when the one after it frees up
  assign s2_adv       = s2_valid && load_ready;
  assign s1_adv       = s1_valid && (!s2_valid || s2_adv);
  assign blocks.ready = !s1_valid || s1_adv;
  assign accept       = blocks.valid && blocks.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // Step the block position once per accepted block
  always_comb begin
    if ({1'b0, block_column} + BPR_W'(1) >= row_limit) begin
      block_column_next = '0;
      block_row_next    = block_row + 1'b1;
    end else begin
      block_column_next = block_column + 1'b1;
      block_row_next    = block_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
    end else if (accept) begin
      block_column <= block_column_next;
      block_row    <= block_row_next;
    end
  end

  // Side data pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_codes  <= blocks.color_codes;
      s1_acodes <= blocks.alpha_codes;
      s1_a0     <= blocks.alpha_end0;
      s1_a1     <= blocks.alpha_end1;
      s1_col    <= block_column;
      s1_row    <= block_row;
    end
    if (s1_adv) begin
      s2_codes  <= s1_codes;
      s2_acodes <= s1_acodes;
      s2_a0     <= s1_a0;
      s2_a1     <= s1_a1;
      s2_col    <= s1_col;
      s2_row    <= s1_row;
    end
  end

  // Color lanes: one per channel, endpoints expanded from RGB565
  bc13_color_lane u_lane_r (
    .clk  (clk),
    .en1  (accept),
    .en2  (s1_adv),
    .end0 (exp5(blocks.color_end0[15:11])),
    .end1 (exp5(blocks.color_end1[15:11])),
    .pal  (pal_r)
  );

  bc13_color_lane u_lane_g (
    .clk  (clk),
    .en1  (accept),
    .en2  (s1_adv),
    .end0 (exp6(blocks.color_end0[10:5])),
    .end1 (exp6(blocks.color_end1[10:5])),
    .pal  (pal_g)
  );

  bc13_color_lane u_lane_b (
    .clk  (clk),
    .en1  (accept),
    .en2  (s1_adv),
    .end0 (exp5(blocks.color_end0[4:0])),
    .end1 (exp5(blocks.color_end1[4:0])),
    .pal  (pal_b)
  );

  // Alpha lanes: palette entries two through seven; entries zero and one
  // are the endpoints themselves
  for (genvar i = 2; i < 8; i++) begin : g_alpha
    bc13_alpha_lane u_lane_a (
      .clk   (clk),
      .en1   (accept),
      .en2   (s1_adv),
      .idx   (3'(i)),
      .a0    (blocks.alpha_end0),
      .a1    (blocks.alpha_end1),
      .entry (apal[i])
    );
  end

  assign apal[0] = s2_a0;
  assign apal[1] = s2_a1;

  always_comb begin
    s2_blk.pal_r  = pal_r;
    s2_blk.pal_g  = pal_g;
    s2_blk.pal_b  = pal_b;
    s2_blk.apal   = apal;
    s2_blk.codes  = s2_codes;
    s2_blk.acodes = s2_acodes;
    s2_blk.col    = s2_col;
    s2_blk.row    = s2_row;
  end

  // Merge stage: pick palette entries per pixel and emit beats
  bc13_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .format_mode (format_mode),
    .load_valid  (s2_valid),
    .load_ready  (load_ready),
    .load_blk    (s2_blk),
    .pixels      (pixels)
  );

endmodule

// File: bench/bc1_bc3_block_decoder_tb.sv
// ----------------------------------------------------------------------------
// bc1_bc3_block_decoder_tb: self-checking bench for the BC1/BC3 decoder
// Drives compressed blocks through the block channel under bursty traffic,
// stalls the pixel channel on its own pattern, and checks every pixel beat
// against a behavioral decoder kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module bc1_bc3_block_decoder_tb;
  import bc13_pkg::*;

  // Generous: worst case is ~460 blocks x 16 pixels, each behind a rare long
  // stall, plus sender gaps and drain pauses.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;    // first pixel follows accept through the endpoint, palette and merge stages
  localparam int PHASE_BLOCKS = 54;
  localparam int NUM_PHASES   = 8;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [15:0] color_end0;
    logic [15:0] color_end1;
    logic [31:0] color_codes;
    logic [7:0]  alpha_end0;
    logic [7:0]  alpha_end1;
    logic [47:0] alpha_codes;
  } blk_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        last_pixel;
  } pix_t;

  // Behavioral decoder plus the queue of pixels it still owes.
  class pixel_scoreboard;
    logic             bc3_mode;
    logic [BPR_W-1:0] row_width;
    logic [COL_W-1:0] blk_col;
    logic [ROW_W-1:0] blk_row;
    pix_t             pending_px[$];
    int               errors;
    int               blocks_seen;
    int               pixels_seen;

    function new();
      bc3_mode    = 1'b0;
      row_width   = 1;
      blk_col     = '0;
      blk_row     = '0;
      errors      = 0;
      blocks_seen = 0;
      pixels_seen = 0;
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      if (errors < PRINT_CAP)
        $display("MISMATCH pixel %0d: %s got %0d, expected %0d",
                 pixels_seen, what, got, want);
      errors++;
    endtask

    function void set_reg(input bc13_reg_t idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FORMAT_MODE:    bc3_mode  = val[0];
        REG_BLOCKS_PER_ROW: row_width = val[BPR_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(c*255/31) and floor(c*255/63) per channel; [0] red, [2] blue
    function logic [2:0][7:0] expand_rgb565(input logic [15:0] c);
      logic [2:0][7:0] rgb;
      rgb[0] = 8'((int'(c[15:11]) * 255) / 31);
      rgb[1] = 8'((int'(c[10:5]) * 255) / 63);
      rgb[2] = 8'((int'(c[4:0]) * 255) / 31);
      return rgb;
    endfunction

    function void note_block(input blk_t b);
      logic [2:0][7:0] e0, e1;
      logic [7:0]      pal[4][3];
      logic [7:0]      apal[8];
      int unsigned     x0, x1, a0, a1, ci, ai, lim;
      pix_t            p;
      e0 = expand_rgb565(b.color_end0);
      e1 = expand_rgb565(b.color_end1);
      for (int ch = 0; ch < 3; ch++) begin
        x0 = e0[ch];
        x1 = e1[ch];
        pal[0][ch] = e0[ch];
        pal[1][ch] = e1[ch];
        pal[2][ch] = 8'((2 * x0 + x1) / 3);
        pal[3][ch] = 8'((x0 + 2 * x1) / 3);
      end
      a0 = b.alpha_end0;
      a1 = b.alpha_end1;
      apal[0] = b.alpha_end0;
      apal[1] = b.alpha_end1;
      if (a0 > a1) begin
        for (int i = 2; i < 8; i++)
          apal[i] = 8'((a0 * (8 - i) + a1 * (i - 1)) / 7);
      end else begin
        for (int i = 2; i < 6; i++)
          apal[i] = 8'((a0 * (6 - i) + a1 * (i - 1)) / 5);
        apal[6] = 8'd0;
        apal[7] = 8'd255;
      end
      for (int j = 0; j < PIX_PER_BLK; j++) begin
        ci = (b.color_codes >> (2 * j)) & 32'h3;
        ai = 32'((b.alpha_codes >> (3 * j)) & 48'h7);
        p.red        = pal[ci][0];
        p.green      = pal[ci][1];
        p.blue       = pal[ci][2];
        p.alpha      = bc3_mode ? apal[ai] : 8'd255;
        p.pixel_x    = 12'(int'(blk_col) * 4 + (j % 4));
        p.pixel_y    = 12'(int'(blk_row) * 4 + (j / 4));
        p.last_pixel = (j == PIX_PER_BLK - 1);
        pending_px.push_back(p);
      end
      // zero acts as one, oversize clamps to the image width limit
      lim = row_width;
      if (lim < 1) lim = 1;
      if (lim > ROW_LIMIT) lim = ROW_LIMIT;
      if (int'(blk_col) + 1 >= lim) begin
        blk_col = '0;
        blk_row = blk_row + 1'b1;
      end else begin
        blk_col = blk_col + 1'b1;
      end
      blocks_seen++;
    endfunction

    task check_pixel(input pix_t got);
      pix_t want;
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected beat, x", got.pixel_x, -1);
      end else begin
        want = pending_px.pop_front();
        if (got.red !== want.red)         report_mismatch("red", got.red, want.red);
        if (got.green !== want.green)     report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue)       report_mismatch("blue", got.blue, want.blue);
        if (got.alpha !== want.alpha)     report_mismatch("alpha", got.alpha, want.alpha);
        if (got.pixel_x !== want.pixel_x) report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
        if (got.pixel_y !== want.pixel_y) report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
        if (got.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", got.last_pixel, want.last_pixel);
      end
      pixels_seen++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  bc13_reg_t             cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bc13_blk_if blocks ();
  bc13_pix_if pixels ();

  bc1_bc3_block_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blocks    (blocks.sink),
    .pixels    (pixels.source)
  );

  pixel_scoreboard sb;
  int cycles;
  int cfg_writes;

  // Random-phase settings; a width of -1 means pick a small one at random.
  int phase_mode [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 1};
  int phase_width[NUM_PHASES] = '{4, 2, 1, 0, 1024, 6, 2047, -1};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: hold the run to a bounded number of cycles.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TIMEOUT after %0d cycles, %0d pixels still owed",
                 cycles, sb.pending_px.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Watch both channels. Values read here are the ones present before the
  // edge, since all drivers update through nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && blocks.valid && blocks.ready)
      sb.note_block('{blocks.color_end0, blocks.color_end1, blocks.color_codes,
                      blocks.alpha_end0, blocks.alpha_end1, blocks.alpha_codes});
    if (!rst && pixels.valid && pixels.ready)
      sb.check_pixel('{pixels.red, pixels.green, pixels.blue, pixels.alpha,
                       pixels.pixel_x, pixels.pixel_y, pixels.last_pixel});
  end

  // Pixel-side backpressure: switch between stall styles in segments of
  // random length so stalls land on every pixel slot of a block.
  initial begin
    int seg_left;
    int style;
    int stall_left;
    int tick;
    logic rdy;
    seg_left   = 0;
    style      = 0;
    stall_left = 0;
    tick       = 0;
    pixels.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        style    = $urandom_range(0, 3);
        seg_left = $urandom_range(40, 300);
      end
      seg_left--;
      tick++;
      case (style)
        0: rdy = 1'b1;                               // free flow
        1: rdy = ($urandom_range(0, 9) < 6);         // random drops
        2: rdy = (tick % 5) != 0;                    // regular hiccup
        default: begin                               // rare long stalls
          if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
          end else if ($urandom_range(0, 30) == 0) begin
            stall_left = $urandom_range(4, 12);
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
          end
        end
      endcase
      pixels.ready <= rdy;
    end
  end

  // Present one block and hold it until the beat is taken.
  task automatic push_block(input blk_t b);
    blocks.valid       <= 1'b1;
    blocks.color_end0  <= b.color_end0;
    blocks.color_end1  <= b.color_end1;
    blocks.color_codes <= b.color_codes;
    blocks.alpha_end0  <= b.alpha_end0;
    blocks.alpha_end1  <= b.alpha_end1;
    blocks.alpha_codes <= b.alpha_codes;
    @(posedge clk);
    while (!blocks.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every owed pixel, then let the pipe settle.
  task automatic drain_pixels();
    blocks.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One-cycle register write; only called with the decoder idle.
  task automatic write_reg(input bc13_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, CFG_DATA_W'(val));
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_color();
    logic [15:0] corners[5] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
    if ($urandom_range(0, 4) == 0)
      return corners[$urandom_range(0, 4)];
    return 16'($urandom);
  endfunction

  // Random block: endpoints leaning toward the corners, both alpha orderings
  // and equal alpha endpoints all well represented.
  function automatic blk_t random_block();
    blk_t b;
    b.color_end0  = pick_color();
    b.color_end1  = pick_color();
    b.color_codes = $urandom;
    b.alpha_end0  = 8'($urandom);
    b.alpha_end1  = 8'($urandom);
    case ($urandom_range(0, 5))
      0: b.alpha_end1 = b.alpha_end0;
      1: begin b.alpha_end0 = 8'd255; b.alpha_end1 = 8'd0; end
      2: begin b.alpha_end0 = 8'd0;   b.alpha_end1 = 8'd255; end
      default: ;
    endcase
    b.alpha_codes = {16'($urandom), 32'($urandom)};
    return b;
  endfunction

  initial begin
    int   burst_left;
    int   gap;
    int   width;
    int   roll;
    bit   no_gaps;

    sb         = new();
    cfg_writes = 0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_FORMAT_MODE;
    cfg_data   = '0;
    blocks.valid       = 1'b0;
    blocks.color_end0  = '0;
    blocks.color_end1  = '0;
    blocks.color_codes = '0;
    blocks.alpha_end0  = '0;
    blocks.alpha_end1  = '0;
    blocks.alpha_codes = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // ---- directed part ----
    // Reset settings are BC1 and one block per row: alpha fields must be
    // ignored, so load them with junk.
    push_block('{16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'hFF, 8'h00, 48'hFFFF_FFFF_FFFF});
    push_block('{16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 8'h5A, 8'hA5, 48'hFAC6_88FA_C688});
    drain_pixels();

    write_reg(REG_FORMAT_MODE, 1);
    write_reg(REG_BLOCKS_PER_ROW, 3);
    // all-zero and all-one blocks; equal alpha endpoints take the six-entry form
    push_block('{16'h0000, 16'h0000, 32'h0, 8'h00, 8'h00, 48'h0});
    push_block('{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF});
    // every palette and alpha index in one block, both alpha orderings
    push_block('{16'hF800, 16'h07E0, 32'hE4E4E4E4, 8'd255, 8'd0,   48'hFAC6_88FA_C688});
    push_block('{16'h07E0, 16'hF800, 32'hE4E4E4E4, 8'd0,   8'd255, 48'hFAC6_88FA_C688});
    push_block('{16'h001F, 16'hF81F, 32'hE4E4E4E4, 8'd200, 8'd13,  48'hFAC6_88FA_C688});
    push_block('{16'hF81F, 16'h001F, 32'h1B1B1B1B, 8'd13,  8'd200, 48'hFAC6_88FA_C688});
    push_block('{16'h8410, 16'h7BEF, 32'h1B1B1B1B, 8'd128, 8'd128, 48'hFAC6_88FA_C688});
    drain_pixels();

    // zero blocks per row behaves as one: every block opens a new row
    write_reg(REG_BLOCKS_PER_ROW, 0);
    repeat (3) push_block(random_block());
    drain_pixels();

    // over-range row width clamps to the image limit
    write_reg(REG_BLOCKS_PER_ROW, 2047);
    repeat (3) push_block(random_block());
    drain_pixels();

    write_reg(REG_FORMAT_MODE, 0);
    write_reg(REG_BLOCKS_PER_ROW, 1024);
    repeat (3) push_block(random_block());
    drain_pixels();

    // ---- random part ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      width = (phase_width[ph] < 0) ? $urandom_range(1, 40) : phase_width[ph];
      write_reg(REG_FORMAT_MODE, phase_mode[ph]);
      write_reg(REG_BLOCKS_PER_ROW, width);
      no_gaps    = (ph % 3 == 2);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        push_block(random_block());
        // hold off mid-phase until the decoder has emptied completely
        if (ph == 2 && n == PHASE_BLOCKS / 2) begin
          drain_pixels();
          continue;
        end
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          roll = $urandom_range(0, 9);
          if (no_gaps || roll < 4)
            gap = 0;
          else if (roll < 8)
            gap = $urandom_range(1, 8);
          else
            gap = $urandom_range(9, 40);
          if (gap > 0) begin
            blocks.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      drain_pixels();
    end

    repeat (4 * SETTLE) @(posedge clk);
    if (sb.pending_px.size() != 0)
      sb.report_mismatch("pixels left over", sb.pending_px.size(), 0);

    $display("Covered %0d blocks, %0d pixel beats, %0d register writes", sb.blocks_seen,
             sb.pixels_seen, cfg_writes);
    $display("BC1 and BC3 modes, row widths zero through over-range, %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
